// ----- rtl/tct_pkg.sv -----
`timescale 1ns / 1ps
// Shared types and constants for the TCP connection tracker.
// Depends on nothing; every other file of the block imports it.
package tct_pkg;

  // Connection states as reported on the result stream.
  localparam logic [1:0] CS_INIT   = 2'd0;
  localparam logic [1:0] CS_CONN   = 2'd1;
  localparam logic [1:0] CS_CLOSED = 2'd2;

  // Command queue between the front end and the table engine.
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = 2;
  localparam int QCNT_W      = 3;

  localparam int SLOT_W = 6;
  localparam int IN_DATA_W  = 120;
  localparam int OUT_DATA_W = 112;

  // One classified packet, key already normalized to local/remote order.
  typedef struct packed {
    logic        tcp;
    logic        inbound;
    logic        syn;
    logic        close;
    logic        data;
    logic [63:0] key_a;
    logic [31:0] key_p;
  } cmd_t;

  // One table entry: local address high, remote low; same for ports.
  typedef struct packed {
    logic        valid;
    logic [63:0] addrs;
    logic [31:0] ports;
    logic        inbound;
    logic        connected;
  } entry_t;

  typedef struct packed {
    logic              record_valid;
    logic [SLOT_W-1:0] slot;
    logic [31:0]       local_addr;
    logic [31:0]       remote_addr;
    logic [15:0]       local_port;
    logic [15:0]       remote_port;
    logic              conn_inbound;
    logic [1:0]        conn_state;
    logic              info_changed;
    logic              table_full;
  } res_t;

endpackage

// ----- rtl/tct_front.sv -----
`timescale 1ns / 1ps
// Front end of the TCP connection tracker: takes packet transactions,
// normalizes the connection key and classifies the flags. Uses tct_pkg.
module tct_front
  import tct_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 en,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  logic [IN_DATA_W-1:0] s_tdata,
  input  logic                 s_tuser,
  output logic                 push_valid,
  input  logic                 push_ready,
  output cmd_t                 push_cmd
);

  logic        cmd_vld;
  cmd_t        cmd_q;
  cmd_t        cmd_next;
  logic        outb;
  logic [31:0] src_addr;
  logic [31:0] dst_addr;
  logic [15:0] src_port;
  logic [15:0] dst_port;

  assign outb     = s_tdata[0];
  assign src_addr = s_tdata[32:1];
  assign dst_addr = s_tdata[64:33];
  assign src_port = s_tdata[80:65];
  assign dst_port = s_tdata[96:81];

  always_comb begin
    cmd_next.tcp     = s_tuser;
    cmd_next.inbound = ~outb;
    cmd_next.syn     = s_tdata[97];
    cmd_next.close   = s_tdata[98] | s_tdata[99];
    cmd_next.data    = |s_tdata[115:100];
    if (outb) begin
      cmd_next.key_a = {src_addr, dst_addr};
      cmd_next.key_p = {src_port, dst_port};
    end else begin
      cmd_next.key_a = {dst_addr, src_addr};
      cmd_next.key_p = {dst_port, src_port};
    end
  end

  assign s_tready   = en & (~cmd_vld | push_ready);
  assign push_valid = cmd_vld;
  assign push_cmd   = cmd_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      cmd_vld <= 1'b0;
    end else if (s_tvalid && s_tready) begin
      cmd_vld <= 1'b1;
    end else if (push_ready) begin
      cmd_vld <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      cmd_q <= cmd_next;
    end
  end

endmodule

// ----- rtl/tct_fifo.sv -----
`timescale 1ns / 1ps
// Short command queue between the front end and the table engine.
// Uses tct_pkg for the command type and queue depth.
module tct_fifo
  import tct_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic push_valid,
  output logic push_ready,
  input  cmd_t push_cmd,
  output logic pop_valid,
  input  logic pop_ready,
  output cmd_t pop_cmd
);

  cmd_t              q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;
  logic              do_push;
  logic              do_pop;

  assign push_ready = (count != QCNT_W'(QUEUE_DEPTH));
  assign pop_valid  = (count != '0);
  assign pop_cmd    = q[rd_ptr];
  assign do_push    = push_valid & push_ready;
  assign do_pop     = pop_valid & pop_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      q[wr_ptr] <= push_cmd;
    end
  end

endmodule

// ----- rtl/tct_back.sv -----
`timescale 1ns / 1ps
// Table engine of the TCP connection tracker: clears the table after reset,
// scans it for each TCP command, applies the update and registers the result.
// Uses tct_pkg.
module tct_back
  import tct_pkg::*;
#(
  parameter int TABLE_ENTRIES = 64
) (
  input  logic clk,
  input  logic rst,
  output logic ready_for_items,
  input  logic cmd_valid,
  output logic cmd_ready,
  input  cmd_t cmd_in,
  output logic res_valid,
  input  logic res_ready,
  output res_t res
);

  localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_ENTRIES - 1);

  typedef enum logic [3:0] {
    S_CLEAR = 4'b0001,
    S_IDLE  = 4'b0010,
    S_SCAN  = 4'b0100,
    S_ACT   = 4'b1000
  } state_t;

  state_t           state;
  entry_t           mem [TABLE_ENTRIES];
  entry_t           rd_data;
  logic [IDX_W-1:0] idx;
  logic             iss_done;
  logic             chk_vld;
  logic [IDX_W-1:0] chk_idx;
  cmd_t             cmd;
  logic             found;
  logic [IDX_W-1:0] hit;
  logic             hit_inb;
  logic             hit_conn;
  logic             have_free;
  logic [IDX_W-1:0] fr;

  logic             mem_re;
  logic             mem_we;
  logic [IDX_W-1:0] mem_wa;
  entry_t           mem_wd;

  logic             act_go;
  logic             act_we;
  logic [IDX_W-1:0] act_wa;
  entry_t           act_wd;
  res_t             act_res;
  logic             rec_on;
  logic [IDX_W-1:0] rec_slot;
  logic             rec_inb;
  logic [1:0]       rec_state;
  logic             rec_chg;
  logic             rec_full;
  logic             is_match;

  assign ready_for_items = (state != S_CLEAR);
  assign cmd_ready       = (state == S_IDLE);
  assign mem_re          = (state == S_SCAN) & ~iss_done;
  assign act_go          = (state == S_ACT) & (~res_valid | res_ready);
  assign is_match        = rd_data.valid & (rd_data.addrs == cmd.key_a) &
                           (rd_data.ports == cmd.key_p);

  // Decide the update once the scan has seen every slot.
  always_comb begin
    act_we           = 1'b0;
    act_wa           = hit;
    act_wd.valid     = 1'b1;
    act_wd.addrs     = cmd.key_a;
    act_wd.ports     = cmd.key_p;
    act_wd.inbound   = hit_inb;
    act_wd.connected = hit_conn;
    rec_on           = 1'b0;
    rec_slot         = hit;
    rec_inb          = hit_inb;
    rec_state        = CS_INIT;
    rec_chg          = 1'b0;
    rec_full         = 1'b0;
    if (cmd.tcp) begin
      if (cmd.syn) begin
        if (found && !hit_conn) begin
          rec_on = 1'b1;
        end else if (!found && !have_free) begin
          rec_full = 1'b1;
        end else begin
          act_we           = 1'b1;
          act_wa           = found ? hit : fr;
          act_wd.inbound   = cmd.inbound;
          act_wd.connected = cmd.data;
          rec_on           = 1'b1;
          rec_slot         = found ? hit : fr;
          rec_inb          = cmd.inbound;
          rec_state        = cmd.data ? CS_CONN : CS_INIT;
          rec_chg          = 1'b1;
        end
      end else if (cmd.close) begin
        if (found) begin
          act_we       = 1'b1;
          act_wd.valid = 1'b0;
          rec_on       = 1'b1;
          rec_state    = CS_CLOSED;
          rec_chg      = 1'b1;
        end
      end else if (found) begin
        rec_on = 1'b1;
        if (cmd.data && !hit_conn) begin
          act_we           = 1'b1;
          act_wd.connected = 1'b1;
          rec_state        = CS_CONN;
          rec_chg          = 1'b1;
        end else begin
          rec_state = hit_conn ? CS_CONN : CS_INIT;
        end
      end
    end
    act_res = '0;
    act_res.table_full = rec_full;
    if (rec_on) begin
      act_res.record_valid = 1'b1;
      act_res.slot         = SLOT_W'(rec_slot);
      act_res.local_addr   = cmd.key_a[63:32];
      act_res.remote_addr  = cmd.key_a[31:0];
      act_res.local_port   = cmd.key_p[31:16];
      act_res.remote_port  = cmd.key_p[15:0];
      act_res.conn_inbound = rec_inb;
      act_res.conn_state   = rec_state;
      act_res.info_changed = rec_chg;
    end
  end

  always_comb begin
    if (state == S_CLEAR) begin
      mem_we = 1'b1;
      mem_wa = idx;
      mem_wd = '0;
    end else begin
      mem_we = act_go & act_we;
      mem_wa = act_wa;
      mem_wd = act_wd;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    if (mem_re) begin
      rd_data <= mem[idx];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      idx       <= '0;
      iss_done  <= 1'b0;
      chk_vld   <= 1'b0;
      res_valid <= 1'b0;
    end else begin
      chk_vld <= mem_re;
      if (act_go) begin
        res_valid <= 1'b1;
      end else if (res_ready) begin
        res_valid <= 1'b0;
      end
      unique case (state)
        S_CLEAR: begin
          if (idx == LAST_IDX) begin
            idx   <= '0;
            state <= S_IDLE;
          end else begin
            idx <= idx + 1'b1;
          end
        end
        S_IDLE: begin
          if (cmd_valid) begin
            idx      <= '0;
            iss_done <= 1'b0;
            state    <= cmd_in.tcp ? S_SCAN : S_ACT;
          end
        end
        S_SCAN: begin
          if (!iss_done) begin
            if (idx == LAST_IDX) begin
              iss_done <= 1'b1;
            end else begin
              idx <= idx + 1'b1;
            end
          end
          if (chk_vld && chk_idx == LAST_IDX) begin
            state <= S_ACT;
          end
        end
        S_ACT: begin
          if (act_go) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_CLEAR;
        end
      endcase
    end
  end

  // Command and scan bookkeeping, no reset needed.
  always_ff @(posedge clk) begin
    chk_idx <= idx;
    if (state == S_IDLE && cmd_valid) begin
      cmd       <= cmd_in;
      found     <= 1'b0;
      have_free <= 1'b0;
    end else if (state == S_SCAN && chk_vld) begin
      if (rd_data.valid) begin
        if (!found && is_match) begin
          found    <= 1'b1;
          hit      <= chk_idx;
          hit_inb  <= rd_data.inbound;
          hit_conn <= rd_data.connected;
        end
      end else if (!have_free) begin
        have_free <= 1'b1;
        fr        <= chk_idx;
      end
    end
    if (act_go) begin
      res <= act_res;
    end
  end

endmodule

// ----- rtl/tcp_connection_tracker.sv -----
`timescale 1ns / 1ps
// TCP connection tracker: packet headers in, one connection record out per
// packet. Top level; instantiates tct_front, tct_fifo and tct_back, uses tct_pkg.
//
// Each input transaction is one packet header. The tracker keeps a table of
// TABLE_ENTRIES connections keyed by local/remote address and port, with the
// direction taken from the outbound flag. A SYN opens or renews a connection
// in the initiating state, or connected if it carries payload; FIN or RST
// closes and removes it, and payload on a live connection marks it connected;
// every packet yields exactly one output transaction, which is an empty
// record for non-TCP traffic, for packets that match nothing, and for a SYN
// that finds the table full (table_full set). After reset the table is
// cleared one slot per cycle, so the first packet is taken only once every
// slot is clear. The table lives in a single-port-read memory that is scanned
// one slot per cycle: a TCP packet occupies the engine for a full scan, a non-TCP
// packet skips it. A four-deep command queue sits between the header front end
// and the table engine, and the result sits in an output register, so new packets
// keep being taken while a result waits for m_tready, until the queue is full.
module tcp_connection_tracker
  import tct_pkg::*;
#(
  parameter int TABLE_ENTRIES = 64
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  // outbound, src_addr, dst_addr, src_port, dst_port, syn_flag, fin_flag,
  // rst_flag, payload_len, zero pad (from bit 0 up)
  input  logic [IN_DATA_W-1:0]  s_tdata,
  // is_tcp
  input  logic                  s_tuser,
  output logic                  m_tvalid,
  input  logic                  m_tready,
  // slot, local_addr, remote_addr, local_port, remote_port, conn_inbound,
  // conn_state, info_changed, table_full, zero pad (from bit 0 up)
  output logic [OUT_DATA_W-1:0] m_tdata,
  // record_valid
  output logic                  m_tuser
);

  logic en;
  logic push_valid;
  logic push_ready;
  cmd_t push_cmd;
  logic pop_valid;
  logic pop_ready;
  cmd_t pop_cmd;
  res_t res;

  // Front end: header decode and key normalization.
  tct_front u_front (
    .clk        (clk),
    .rst        (rst),
    .en         (en),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .s_tuser    (s_tuser),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_cmd   (push_cmd)
  );

  // Decoupling queue.
  tct_fifo u_fifo (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_cmd   (push_cmd),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_cmd    (pop_cmd)
  );

  // Table engine: lookup, update and the result register.
  tct_back #(
    .TABLE_ENTRIES (TABLE_ENTRIES)
  ) u_back (
    .clk             (clk),
    .rst             (rst),
    .ready_for_items (en),
    .cmd_valid       (pop_valid),
    .cmd_ready       (pop_ready),
    .cmd_in          (pop_cmd),
    .res_valid       (m_tvalid),
    .res_ready       (m_tready),
    .res             (res)
  );

  assign m_tuser = res.record_valid;
  assign m_tdata = {5'b0, res.table_full, res.info_changed, res.conn_state,
                    res.conn_inbound, res.remote_port, res.local_port,
                    res.remote_addr, res.local_addr, res.slot};

endmodule

// ----- sim/tb_top.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for tcp_connection_tracker, driven over its two streams.
// Depends on rtl/tct_pkg.sv and rtl/tcp_connection_tracker.sv; reads no files.
module tb_top
  import tct_pkg::*;
();

  localparam int TABLE_ENTRIES = 64;
  localparam int POOL_SIZE     = 24;
  localparam int RANDOM_ITEMS  = 370;
  // The engine scans the whole table for each TCP packet, and the table is
  // cleared after reset; random stalls on either stream add to the wait. This
  // limit is many times the longest such wait.
  localparam int STALL_LIMIT   = 2000;
  localparam int DRAIN_CYCLES  = 2 * TABLE_ENTRIES + 20;

  // One packet header as the block sees it.
  typedef struct packed {
    logic        is_tcp;
    logic        outbound;
    logic [31:0] src_addr;
    logic [31:0] dst_addr;
    logic [15:0] src_port;
    logic [15:0] dst_port;
    logic        syn_flag;
    logic        fin_flag;
    logic        rst_flag;
    logic [15:0] payload_len;
  } packet_t;

  // A connection key in local/remote order.
  typedef struct packed {
    logic [31:0] local_addr;
    logic [31:0] remote_addr;
    logic [15:0] local_port;
    logic [15:0] remote_port;
  } conn_key_t;

  logic                  clk;
  logic                  rst;
  logic                  s_tvalid;
  logic                  s_tready;
  logic [IN_DATA_W-1:0]  s_tdata;
  logic                  s_tuser;
  logic                  m_tvalid;
  logic                  m_tready;
  logic [OUT_DATA_W-1:0] m_tdata;
  logic                  m_tuser;

  tcp_connection_tracker #(
    .TABLE_ENTRIES(TABLE_ENTRIES)
  ) dut (
    .clk     (clk),
    .rst     (rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata (s_tdata),
    .s_tuser (s_tuser),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata),
    .m_tuser (m_tuser)
  );

  // Shadow copy of the connection table, updated as each packet is accepted.
  bit          conn_valid     [TABLE_ENTRIES];
  logic [63:0] conn_addrs     [TABLE_ENTRIES];
  logic [31:0] conn_ports     [TABLE_ENTRIES];
  bit          conn_inbound   [TABLE_ENTRIES];
  bit          conn_connected [TABLE_ENTRIES];

  res_t      pending_records[$];
  conn_key_t key_pool[POOL_SIZE];
  int        mismatches;
  int        quiet_cycles;
  bit        idle_on;
  res_t      got_rec;
  res_t      want_rec;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Prediction
  // ---------------------------------------------------------------------------

  // Builds the record reported for slot s of the shadow table.
  function automatic res_t slot_record(int s, logic [1:0] st, bit changed);
    res_t r;
    r = '0;
    r.record_valid = 1'b1;
    r.slot         = s[SLOT_W-1:0];
    r.local_addr   = conn_addrs[s][63:32];
    r.remote_addr  = conn_addrs[s][31:0];
    r.local_port   = conn_ports[s][31:16];
    r.remote_port  = conn_ports[s][15:0];
    r.conn_inbound = conn_inbound[s];
    r.conn_state   = st;
    r.info_changed = changed;
    return r;
  endfunction

  // Applies one packet to the shadow table and returns the record it causes.
  function automatic res_t track_packet(packet_t p);
    res_t        r;
    logic [63:0] key_a;
    logic [31:0] key_p;
    int          hit;
    int          free_slot;
    bit          found;
    bit          have_free;
    bit          changed;
    r = '0;
    hit = 0;
    free_slot = 0;
    found = 1'b0;
    have_free = 1'b0;
    changed = 1'b0;
    if (!p.is_tcp) return r;

    // Normalize direction: the local side is the source of an outbound packet.
    if (p.outbound) begin
      key_a = {p.src_addr, p.dst_addr};
      key_p = {p.src_port, p.dst_port};
    end else begin
      key_a = {p.dst_addr, p.src_addr};
      key_p = {p.dst_port, p.src_port};
    end

    for (int i = 0; i < TABLE_ENTRIES; i++) begin
      if (conn_valid[i]) begin
        if (!found && conn_addrs[i] == key_a && conn_ports[i] == key_p) begin
          found = 1'b1;
          hit = i;
        end
      end else if (!have_free) begin
        have_free = 1'b1;
        free_slot = i;
      end
    end

    if (p.syn_flag) begin
      // A repeated SYN while still initiating leaves the entry alone.
      if (found && !conn_connected[hit]) return slot_record(hit, CS_INIT, 1'b0);
      if (!found) begin
        if (!have_free) begin
          r.table_full = 1'b1;
          return r;
        end
        hit = free_slot;
      end
      conn_valid[hit]     = 1'b1;
      conn_addrs[hit]     = key_a;
      conn_ports[hit]     = key_p;
      conn_inbound[hit]   = !p.outbound;
      conn_connected[hit] = 1'b0;
      found = 1'b1;
      changed = 1'b1;
    end else if (p.fin_flag || p.rst_flag) begin
      if (found) begin
        conn_valid[hit] = 1'b0;
        return slot_record(hit, CS_CLOSED, 1'b1);
      end
    end

    if (!found) return r;
    if (p.payload_len != 16'd0 && !conn_connected[hit]) begin
      conn_connected[hit] = 1'b1;
      changed = 1'b1;
    end
    return slot_record(hit, conn_connected[hit] ? CS_CONN : CS_INIT, changed);
  endfunction

  function automatic int free_slots();
    int n;
    n = 0;
    for (int i = 0; i < TABLE_ENTRIES; i++)
      if (!conn_valid[i]) n++;
    return n;
  endfunction

  // ---------------------------------------------------------------------------
  // Packet construction
  // ---------------------------------------------------------------------------

  function automatic conn_key_t random_key();
    conn_key_t k;
    k.local_addr  = $urandom();
    k.remote_addr = $urandom();
    k.local_port  = 16'($urandom());
    k.remote_port = 16'($urandom());
    return k;
  endfunction

  // A TCP packet on connection k, seen from the given direction.
  function automatic packet_t key_packet(conn_key_t k, bit outb, bit syn, bit fin,
                                         bit rsf, logic [15:0] len);
    packet_t p;
    p.is_tcp      = 1'b1;
    p.outbound    = outb;
    p.src_addr    = outb ? k.local_addr  : k.remote_addr;
    p.dst_addr    = outb ? k.remote_addr : k.local_addr;
    p.src_port    = outb ? k.local_port  : k.remote_port;
    p.dst_port    = outb ? k.remote_port : k.local_port;
    p.syn_flag    = syn;
    p.fin_flag    = fin;
    p.rst_flag    = rsf;
    p.payload_len = len;
    return p;
  endfunction

  function automatic logic [15:0] random_len();
    return $urandom_range(0, 1) ? 16'd0 : 16'($urandom());
  endfunction

  // ---------------------------------------------------------------------------
  // Driving
  // ---------------------------------------------------------------------------

  // Sends one packet. Entered and left just after a falling edge; valid stays
  // high into the next call unless that call opens a gap.
  task automatic send_packet(packet_t p);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= p.is_tcp;
    s_tdata  <= {4'b0, p.payload_len, p.rst_flag, p.fin_flag, p.syn_flag,
                 p.dst_port, p.src_port, p.dst_addr, p.src_addr, p.outbound};
    do @(posedge clk); while (!s_tready);
    pending_records.push_back(track_packet(p));
    @(negedge clk);
  endtask

  // Back-pressure on the result stream in random bursts while idling is on.
  initial begin
    m_tready = 1'b1;
    forever begin
      @(negedge clk);
      if (idle_on && $urandom_range(0, 5) == 0) begin
        m_tready <= 1'b0;
        repeat ($urandom_range(1, 15)) @(negedge clk);
        m_tready <= 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Checking
  // ---------------------------------------------------------------------------

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    mismatches++;
    $display("MISMATCH %s: got %0h, expected %0h at %0t ns", what, got, want, $realtime);
  endtask

  task automatic check_field(string what, logic [63:0] got, logic [63:0] want);
    if (got !== want) report_mismatch(what, got, want);
  endtask

  // Every result transaction is compared with the oldest pending record.
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      got_rec.record_valid = m_tuser;
      got_rec.slot         = m_tdata[5:0];
      got_rec.local_addr   = m_tdata[37:6];
      got_rec.remote_addr  = m_tdata[69:38];
      got_rec.local_port   = m_tdata[85:70];
      got_rec.remote_port  = m_tdata[101:86];
      got_rec.conn_inbound = m_tdata[102];
      got_rec.conn_state   = m_tdata[104:103];
      got_rec.info_changed = m_tdata[105];
      got_rec.table_full   = m_tdata[106];
      if (pending_records.size() == 0) begin
        report_mismatch("result with nothing pending", 64'(m_tdata), 64'd0);
      end else begin
        want_rec = pending_records.pop_front();
        check_field("record_valid", 64'(got_rec.record_valid),
                    64'(want_rec.record_valid));
        check_field("slot",         64'(got_rec.slot),         64'(want_rec.slot));
        check_field("local_addr",   64'(got_rec.local_addr),   64'(want_rec.local_addr));
        check_field("remote_addr",  64'(got_rec.remote_addr),  64'(want_rec.remote_addr));
        check_field("local_port",   64'(got_rec.local_port),   64'(want_rec.local_port));
        check_field("remote_port",  64'(got_rec.remote_port),  64'(want_rec.remote_port));
        check_field("conn_inbound", 64'(got_rec.conn_inbound),
                    64'(want_rec.conn_inbound));
        check_field("conn_state",   64'(got_rec.conn_state),   64'(want_rec.conn_state));
        check_field("info_changed", 64'(got_rec.info_changed),
                    64'(want_rec.info_changed));
        check_field("table_full",   64'(got_rec.table_full),   64'(want_rec.table_full));
      end
    end
  end

  // Watchdog: ends the run when neither stream moves for too long.
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles == STALL_LIMIT) begin
        $display("watchdog expired after %0d idle cycles", STALL_LIMIT);
        $display("tcp_connection_tracker regression: fail");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Walks one connection at a time through a set of flag combinations and cases.
  task automatic test_directed();
    conn_key_t ka;
    conn_key_t kb;
    conn_key_t kc;
    conn_key_t kd;
    packet_t   p;
    ka = '1;
    kb = '0;
    kc = random_key();
    kd = random_key();
    // Not TCP, with every other field set: empty record, table untouched.
    p = key_packet(ka, 1'b1, 1'b1, 1'b1, 1'b1, 16'hFFFF);
    p.is_tcp = 1'b0;
    send_packet(p);
    // Plain, FIN and RST packets that match nothing.
    send_packet(key_packet(ka, 1'b1, 1'b0, 1'b0, 1'b0, 16'hFFFF));
    send_packet(key_packet(ka, 1'b0, 1'b0, 1'b1, 1'b0, 16'd0));
    send_packet(key_packet(kb, 1'b1, 1'b0, 1'b0, 1'b1, 16'd1));
    // Open A outbound, then a repeated SYN with payload leaves it initiating.
    send_packet(key_packet(ka, 1'b1, 1'b1, 1'b0, 1'b0, 16'd0));
    send_packet(key_packet(ka, 1'b0, 1'b1, 1'b0, 1'b0, 16'h8000));
    // Payload from the far side connects it, then a second payload changes nothing.
    send_packet(key_packet(ka, 1'b0, 1'b0, 1'b0, 1'b0, 16'h0001));
    send_packet(key_packet(ka, 1'b1, 1'b0, 1'b0, 1'b0, 16'hFFFF));
    // SYN on a connected entry renews it in place; its payload reconnects it.
    send_packet(key_packet(ka, 1'b0, 1'b1, 1'b0, 1'b0, 16'h00FF));
    send_packet(key_packet(ka, 1'b1, 1'b1, 1'b0, 1'b0, 16'd0));
    // Open B inbound; SYN with FIN acts as a SYN; RST then closes it.
    send_packet(key_packet(kb, 1'b0, 1'b1, 1'b0, 1'b0, 16'd0));
    send_packet(key_packet(kb, 1'b1, 1'b1, 1'b1, 1'b0, 16'd0));
    send_packet(key_packet(kb, 1'b1, 1'b0, 1'b0, 1'b1, 16'd0));
    // Close A with FIN; afterwards A is gone.
    send_packet(key_packet(ka, 1'b1, 1'b0, 1'b1, 1'b0, 16'd7));
    send_packet(key_packet(ka, 1'b1, 1'b0, 1'b0, 1'b0, 16'd7));
    // C takes the lowest free slot; SYN with RST on no match opens D.
    send_packet(key_packet(kc, 1'b1, 1'b1, 1'b0, 1'b0, 16'd0));
    send_packet(key_packet(kd, 1'b0, 1'b1, 1'b0, 1'b1, 16'd0));
    // FIN with RST and payload closes C; D connects, then closes.
    send_packet(key_packet(kc, 1'b0, 1'b0, 1'b1, 1'b1, 16'h1234));
    send_packet(key_packet(kd, 1'b1, 1'b0, 1'b0, 1'b0, 16'hFFFF));
    send_packet(key_packet(kd, 1'b0, 1'b0, 1'b1, 1'b0, 16'd0));
  endtask

  // Fills every slot, then probes the full table, then empties it again.
  task automatic test_table_full();
    conn_key_t k;
    k = random_key();
    while (free_slots() > 0) begin
      k = random_key();
      send_packet(key_packet(k, 1'($urandom_range(0, 1)), 1'b1, 1'b0, 1'b0,
                             random_len()));
    end
    // New SYNs are refused, with and without close flags.
    send_packet(key_packet(random_key(), 1'b1, 1'b1, 1'b0, 1'b0, 16'd0));
    send_packet(key_packet(random_key(), 1'b0, 1'b1, 1'b1, 1'b1, 16'd9));
    // A close on an unknown key still gives an empty record.
    send_packet(key_packet(random_key(), 1'b0, 1'b0, 1'b1, 1'b0, 16'd0));
    // A SYN on the last entry opened still matches while the table is full.
    send_packet(key_packet(k, 1'b1, 1'b1, 1'b0, 1'b0, 16'd0));
    send_packet(key_packet(k, 1'b0, 1'b1, 1'b0, 1'b0, 16'd0));
    // Tear down every entry from a random side with RST, some with FIN as well.
    for (int i = 0; i < TABLE_ENTRIES; i++) begin
      if (conn_valid[i]) begin
        k = {conn_addrs[i], conn_ports[i]};
        send_packet(key_packet(k, 1'($urandom_range(0, 1)), 1'b0,
                               1'($urandom_range(0, 1)), 1'b1, random_len()));
      end
    end
  endtask

  // Mostly traffic on a small set of connections, some of it raw noise.
  task automatic test_random_traffic();
    packet_t p;
    int      pick;
    int      flags;
    for (int i = 0; i < POOL_SIZE; i++) key_pool[i] = random_key();
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      // Idling changes every 50 packets and is off for the final stretch.
      if (n % 50 == 0) idle_on = (n < RANDOM_ITEMS - 100) ? 1'($urandom_range(0, 1)) : 1'b0;
      pick = $urandom_range(0, 99);
      if (pick < 12) begin
        p = packet_t'(117'({$urandom(), $urandom(), $urandom(), $urandom()}));
      end else begin
        if (pick < 16) key_pool[$urandom_range(0, POOL_SIZE - 1)] = random_key();
        flags = $urandom_range(0, 9);
        p = key_packet(key_pool[$urandom_range(0, POOL_SIZE - 1)],
                       1'($urandom_range(0, 1)), flags < 3, flags == 3 || flags == 5,
                       flags == 4 || flags == 5, random_len());
        // Extra close bits on a SYN exercise the SYN priority.
        if (flags < 3) begin
          p.fin_flag = $urandom_range(0, 3) == 0;
          p.rst_flag = $urandom_range(0, 3) == 0;
        end
        p.is_tcp = $urandom_range(0, 19) != 0;
      end
      send_packet(p);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------

  initial begin
    rst          = 1'b1;
    s_tvalid     = 1'b0;
    s_tdata      = '0;
    s_tuser      = 1'b0;
    mismatches   = 0;
    quiet_cycles = 0;
    idle_on      = 1'b0;
    for (int i = 0; i < TABLE_ENTRIES; i++) begin
      conn_valid[i]     = 1'b0;
      conn_addrs[i]     = '0;
      conn_ports[i]     = '0;
      conn_inbound[i]   = 1'b0;
      conn_connected[i] = 1'b0;
    end
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    idle_on = 1'b1;
    test_directed();
    test_table_full();
    test_random_traffic();
    s_tvalid <= 1'b0;

    // Drain the remaining results, then give the block time to show any extra.
    while (pending_records.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (pending_records.size() != 0)
      report_mismatch("records never delivered", 64'(pending_records.size()), 64'd0);

    if (mismatches == 0) begin
      $display("tcp_connection_tracker regression: pass");
    end else begin
      $display("tcp_connection_tracker regression: fail");
    end
    $finish;
  end

endmodule
